/* rtl/core/organized_grid_triangulator_defines.svh */
// Assertion macros used by the port-level checker of the grid triangulator.
// Needs clk and rst_n in the scope of every use.
`ifndef ORGANIZED_GRID_TRIANGULATOR_DEFINES_SVH
`define ORGANIZED_GRID_TRIANGULATOR_DEFINES_SVH

// same-cycle implication
`define OGT_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define OGT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/ogt_pkg.sv */
// Shared types and constants for the organized grid triangulator.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package ogt_pkg;

    localparam int IDX_W       = 20;   // corner index width
    localparam int FACE_W      = 21;   // face count width
    localparam int CFG_W       = 11;   // size register width
    localparam int DIM_W       = 13;   // clamped size, holds up to 8191
    localparam int APB_DATA_W  = 32;
    localparam int APB_ADDR_W  = 3;
    localparam int S_TDATA_W   = 8;
    localparam int M_TDATA_W   = 88;
    localparam int DIM_MIN     = 2;
    localparam int MAX_WIDTH_DEF  = 1024;
    localparam int MAX_HEIGHT_DEF = 1024;

    localparam logic [FACE_W-1:0] FACE_MAX     = 21'h1FFFFF;
    localparam logic [CFG_W-1:0]  WIDTH_RESET  = 11'd640;
    localparam logic [CFG_W-1:0]  HEIGHT_RESET = 11'd480;

    typedef enum logic {
        REG_FRAME_WIDTH  = 1'b0,
        REG_FRAME_HEIGHT = 1'b1
    } reg_idx_t;

    // effective frame size plus a restart pulse on any register write
    typedef struct packed {
        logic             restart;
        logic [DIM_W-1:0] eff_w;
        logic [DIM_W-1:0] eff_h;
    } cfg_t;

    // one triangle on its way out
    typedef struct packed {
        logic              last;
        logic [FACE_W-1:0] face_total;
        logic [IDX_W-1:0]  c;
        logic [IDX_W-1:0]  b;
        logic [IDX_W-1:0]  a;
    } tri_t;

endpackage
`default_nettype wire

/* rtl/core/organized_grid_triangulator.sv */
// Organized grid triangulator. Takes one valid-depth flag per pixel of an
// organized frame in raster order (s_tdata bit 0) and streams triangle faces
// as linear vertex indices. For each valid pixel (u,v) whose next valid pixel
// down its column is row i and whose next valid pixel along its row is column
// k, the pair (v*W+u, v*W+k, i*W+u) and (i*W+k, v*W+k, i*W+u) is sent when
// pixel (u,i) arrives; m_tlast marks the second triangle of the pair and a
// saturating per-frame face count rides along. The column table has a single
// write port and each pixel needs up to two entry writes (link the previous
// valid pixel of the row, then its own column), so a new pixel is accepted
// only as the previous one does its second write, and a pair of triangles
// drains one per cycle while m_tready is high, via a two-entry output buffer.
// The column table needs no clearing pass after reset: the top row of every
// frame rewrites each column entry before any lower row reads it. Any
// register write restarts the frame; write registers only while idle.
`timescale 1ns / 1ps
`default_nettype none
module organized_grid_triangulator #(
    parameter int MAX_WIDTH  = ogt_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = ogt_pkg::MAX_HEIGHT_DEF
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    // APB configuration: frame_width at 0x0, frame_height at 0x4
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [ogt_pkg::APB_ADDR_W-1:0]  paddr,
    input  wire logic [ogt_pkg::APB_DATA_W-1:0]  pwdata,
    output logic      [ogt_pkg::APB_DATA_W-1:0]  prdata,
    output logic                                 pready,
    // pixel stream
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    input  wire logic [ogt_pkg::S_TDATA_W-1:0]   s_tdata,   // [0] point_valid, rest zero
    // triangle stream
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    output logic      [ogt_pkg::M_TDATA_W-1:0]   m_tdata,   // [19:0] corner_a,
                                                            // [39:20] corner_b,
                                                            // [59:40] corner_c,
                                                            // [80:60] face_total
    output logic                                 m_tlast    // last_of_run
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int RW = $clog2(MAX_HEIGHT);
    localparam int EW = CW + ogt_pkg::IDX_W + 2;

    ogt_pkg::cfg_t cfg;
    ogt_pkg::tri_t push_item;
    logic          push;
    logic          push_ok;
    logic          tbl_rd_en;
    logic [CW-1:0] tbl_rd_addr;
    logic [EW-1:0] tbl_rd_data;
    logic          tbl_wr_en;
    logic [CW-1:0] tbl_wr_addr;
    logic [EW-1:0] tbl_wr_data;

    ogt_regs #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // one entry per column: last valid row (as its base index), right link
    ogt_table #(
        .DEPTH  (MAX_WIDTH),
        .ADDR_W (CW),
        .DATA_W (EW)
    ) u_table (
        .clk     (clk),
        .rd_en   (tbl_rd_en),
        .rd_addr (tbl_rd_addr),
        .rd_data (tbl_rd_data),
        .wr_en   (tbl_wr_en),
        .wr_addr (tbl_wr_addr),
        .wr_data (tbl_wr_data)
    );

    // raster counters, table read-modify-write, triangle assembly
    ogt_seq #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .CW         (CW),
        .RW         (RW),
        .EW         (EW)
    ) u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .in_point    (s_tdata[0]),
        .tbl_rd_en   (tbl_rd_en),
        .tbl_rd_addr (tbl_rd_addr),
        .tbl_rd_data (tbl_rd_data),
        .tbl_wr_en   (tbl_wr_en),
        .tbl_wr_addr (tbl_wr_addr),
        .tbl_wr_data (tbl_wr_data),
        .push        (push),
        .push_item   (push_item),
        .push_ok     (push_ok)
    );

    // output register stage, decouples the sequencer from m_tready
    ogt_obuf u_obuf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .push_ok   (push_ok),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

endmodule
`default_nettype wire

/* rtl/core/ogt_regs.sv */
// APB register file: frame width and height, clamped to the supported range.
// Depends on ogt_pkg.
`timescale 1ns / 1ps
`default_nettype none
module ogt_regs #(
    parameter int MAX_WIDTH  = ogt_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = ogt_pkg::MAX_HEIGHT_DEF
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [ogt_pkg::APB_ADDR_W-1:0]  paddr,
    input  wire logic [ogt_pkg::APB_DATA_W-1:0]  pwdata,
    output logic      [ogt_pkg::APB_DATA_W-1:0]  prdata,
    output logic                                 pready,
    output ogt_pkg::cfg_t                        cfg
);

    logic [ogt_pkg::CFG_W-1:0] width_reg;
    logic [ogt_pkg::CFG_W-1:0] height_reg;
    logic                      wr;
    ogt_pkg::reg_idx_t         idx;
    logic [ogt_pkg::DIM_W-1:0] w_ext;
    logic [ogt_pkg::DIM_W-1:0] h_ext;

    assign pready = 1'b1;
    assign wr     = psel && penable && pwrite;
    // word index; the byte offset bits are not decoded
    assign idx    = ogt_pkg::reg_idx_t'(paddr[2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= ogt_pkg::WIDTH_RESET;
            height_reg <= ogt_pkg::HEIGHT_RESET;
        end
        else if (wr)
        begin
            unique case (idx)
                ogt_pkg::REG_FRAME_WIDTH:  width_reg  <= pwdata[ogt_pkg::CFG_W-1:0];
                ogt_pkg::REG_FRAME_HEIGHT: height_reg <= pwdata[ogt_pkg::CFG_W-1:0];
                default:                   ;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            ogt_pkg::REG_FRAME_WIDTH:  prdata = ogt_pkg::APB_DATA_W'(width_reg);
            ogt_pkg::REG_FRAME_HEIGHT: prdata = ogt_pkg::APB_DATA_W'(height_reg);
            default:                   prdata = '0;
        endcase
    end

    assign w_ext = ogt_pkg::DIM_W'(width_reg);
    assign h_ext = ogt_pkg::DIM_W'(height_reg);

    always_comb
    begin
        cfg.restart = wr;
        if (w_ext < ogt_pkg::DIM_W'(ogt_pkg::DIM_MIN))
            cfg.eff_w = ogt_pkg::DIM_W'(ogt_pkg::DIM_MIN);
        else if (w_ext > ogt_pkg::DIM_W'(MAX_WIDTH))
            cfg.eff_w = ogt_pkg::DIM_W'(MAX_WIDTH);
        else
            cfg.eff_w = w_ext;
        if (h_ext < ogt_pkg::DIM_W'(ogt_pkg::DIM_MIN))
            cfg.eff_h = ogt_pkg::DIM_W'(ogt_pkg::DIM_MIN);
        else if (h_ext > ogt_pkg::DIM_W'(MAX_HEIGHT))
            cfg.eff_h = ogt_pkg::DIM_W'(MAX_HEIGHT);
        else
            cfg.eff_h = h_ext;
    end

endmodule
`default_nettype wire

/* rtl/core/ogt_table.sv */
// Column table: one entry per column, registered synchronous read.
// Entry is {tag, row base index, right neighbor column, right known}.
`timescale 1ns / 1ps
`default_nettype none
module ogt_table #(
    parameter int DEPTH  = ogt_pkg::MAX_WIDTH_DEF,
    parameter int ADDR_W = $clog2(DEPTH),
    parameter int DATA_W = ADDR_W + ogt_pkg::IDX_W + 2
) (
    input  wire logic              clk,
    input  wire logic              rd_en,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [DATA_W-1:0] rd_data,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [DATA_W-1:0] wr_data
);

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
            rd_data <= mem[rd_addr];
    end

endmodule
`default_nettype wire

/* rtl/core/ogt_seq.sv */
// Pixel sequencer: raster counters, column table read-modify-write, face pairs.
// Depends on ogt_pkg; drives ogt_table and ogt_obuf.
`timescale 1ns / 1ps
`default_nettype none
module ogt_seq #(
    parameter int MAX_WIDTH  = ogt_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = ogt_pkg::MAX_HEIGHT_DEF,
    parameter int CW         = $clog2(MAX_WIDTH),
    parameter int RW         = $clog2(MAX_HEIGHT),
    parameter int EW         = CW + ogt_pkg::IDX_W + 2
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire ogt_pkg::cfg_t cfg,
    input  wire logic          in_valid,
    output logic               in_ready,
    input  wire logic          in_point,
    output logic               tbl_rd_en,
    output logic [CW-1:0]      tbl_rd_addr,
    input  wire logic [EW-1:0] tbl_rd_data,
    output logic               tbl_wr_en,
    output logic [CW-1:0]      tbl_wr_addr,
    output logic [EW-1:0]      tbl_wr_data,
    output logic               push,
    output ogt_pkg::tri_t      push_item,
    input  wire logic          push_ok
);

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_ONE,
        PH_TWO
    } phase_t;

    localparam int IW = ogt_pkg::IDX_W;

    // control state
    phase_t                     phase_reg, phase_next;
    logic [CW-1:0]              col_reg, col_next;
    logic [RW-1:0]              row_reg, row_next;
    logic [IW-1:0]              rb_reg, rb_next;
    logic                       pend_ok_reg, pend_ok_next;
    logic [CW-1:0]              pend_col_reg, pend_col_next;
    logic                       tag_reg, tag_next;
    logic [ogt_pkg::FACE_W-1:0] fc_reg, fc_next;
    logic                       emit_s_reg, emit_s_next;

    // per-item payload
    logic [CW-1:0] u_s_reg;
    logic [IW-1:0] vb_s_reg;
    logic          v0_s_reg;
    logic          pv_s_reg;
    logic          pok_s_reg;
    logic [CW-1:0] pcol_s_reg;
    logic          tag_s_reg;
    logic          lastc_s_reg;
    logic          fend_s_reg;
    logic [IW-1:0] t2_a_reg;
    logic [IW-1:0] t2_b_reg;
    logic [IW-1:0] t2_c_reg;

    logic                       accept;
    logic                       p1_go;
    logic                       p2_go;
    logic                       emit;
    logic                       e_ok;
    logic [CW-1:0]              e_right;
    logic [IW-1:0]              e_base;
    logic                       e_tag;
    logic [IW-1:0]              tl;
    logic [IW-1:0]              tr;
    logic [IW-1:0]              bl;
    logic [IW-1:0]              br;
    logic [ogt_pkg::FACE_W-1:0] fc_inc;
    logic [CW:0]                col_p1;
    logic [RW:0]                row_p1;
    logic                       last_col;
    logic                       last_row;
    logic                       wa_en;
    logic [CW-1:0]              wa_addr;
    logic [EW-1:0]              wa_data;
    logic                       wb_en;
    logic [EW-1:0]              wb_data;

    assign e_ok    = tbl_rd_data[0];
    assign e_right = tbl_rd_data[CW:1];
    assign e_base  = tbl_rd_data[CW+IW:CW+1];
    assign e_tag   = tbl_rd_data[EW-1];

    assign emit  = pv_s_reg && !v0_s_reg && (e_tag == tag_s_reg) && e_ok;
    assign p1_go = (phase_reg == PH_ONE) && (!emit || push_ok);
    assign p2_go = (phase_reg == PH_TWO) && (!emit_s_reg || push_ok);

    assign in_ready = (phase_reg == PH_IDLE) || p2_go;
    assign accept   = in_valid && in_ready;

    assign tbl_rd_en   = accept;
    assign tbl_rd_addr = col_reg;

    // corner indices, kept modulo 2^20
    assign tl = IW'(e_base + IW'(u_s_reg));
    assign tr = IW'(e_base + IW'(e_right));
    assign bl = IW'(vb_s_reg + IW'(u_s_reg));
    assign br = IW'(vb_s_reg + IW'(e_right));

    assign fc_inc = (fc_reg == ogt_pkg::FACE_MAX) ? fc_reg
                                                  : ogt_pkg::FACE_W'(fc_reg + 1'b1);

    assign col_p1   = {1'b0, col_reg} + 1'b1;
    assign row_p1   = {1'b0, row_reg} + 1'b1;
    assign last_col = (col_p1 == (CW+1)'(cfg.eff_w));
    assign last_row = (row_p1 == (RW+1)'(cfg.eff_h));

    // slot A: link the previous valid pixel of the row to this one, or
    // close the row's open pixel when the row ends on an invalid one
    always_comb
    begin
        wa_addr = pcol_s_reg;
        if (pv_s_reg)
        begin
            wa_en   = pok_s_reg;
            wa_data = {tag_s_reg, vb_s_reg, u_s_reg, 1'b1};
        end
        else
        begin
            wa_en   = lastc_s_reg && pok_s_reg;
            wa_data = {tag_s_reg, vb_s_reg, CW'(0), 1'b0};
        end
    end

    // slot B: this column's own entry; a valid pixel ending the row has no
    // right neighbor, an invalid one in the top row marks the column empty
    always_comb
    begin
        if (pv_s_reg)
        begin
            wb_en   = lastc_s_reg;
            wb_data = {tag_s_reg, vb_s_reg, CW'(0), 1'b0};
        end
        else
        begin
            wb_en   = v0_s_reg;
            wb_data = {~tag_s_reg, vb_s_reg, CW'(0), 1'b0};
        end
    end

    always_comb
    begin
        tbl_wr_en   = 1'b0;
        tbl_wr_addr = wa_addr;
        tbl_wr_data = wa_data;
        push        = 1'b0;
        push_item   = '0;
        if (phase_reg == PH_ONE)
        begin
            tbl_wr_en            = p1_go && wa_en;
            push                 = p1_go && emit;
            push_item.a          = tl;
            push_item.b          = tr;
            push_item.c          = bl;
            push_item.face_total = fc_inc;
            push_item.last       = 1'b0;
        end
        else if (phase_reg == PH_TWO)
        begin
            tbl_wr_en            = p2_go && wb_en;
            tbl_wr_addr          = u_s_reg;
            tbl_wr_data          = wb_data;
            push                 = p2_go && emit_s_reg;
            push_item.a          = t2_a_reg;
            push_item.b          = t2_b_reg;
            push_item.c          = t2_c_reg;
            push_item.face_total = fc_inc;
            push_item.last       = 1'b1;
        end
    end

    always_comb
    begin
        phase_next    = phase_reg;
        col_next      = col_reg;
        row_next      = row_reg;
        rb_next       = rb_reg;
        pend_ok_next  = pend_ok_reg;
        pend_col_next = pend_col_reg;
        tag_next      = tag_reg;
        fc_next       = fc_reg;
        emit_s_next   = emit_s_reg;

        unique case (phase_reg)
            PH_IDLE:
            begin
                if (accept)
                    phase_next = PH_ONE;
            end
            PH_ONE:
            begin
                if (p1_go)
                begin
                    phase_next  = PH_TWO;
                    emit_s_next = emit;
                    if (emit)
                        fc_next = fc_inc;
                end
            end
            PH_TWO:
            begin
                if (p2_go)
                begin
                    phase_next = accept ? PH_ONE : PH_IDLE;
                    if (fend_s_reg)
                        fc_next = '0;
                    else if (emit_s_reg)
                        fc_next = fc_inc;
                end
            end
            default:
                phase_next = PH_IDLE;
        endcase

        if (accept)
        begin
            if (in_point)
            begin
                pend_ok_next  = 1'b1;
                pend_col_next = col_reg;
            end
            if (last_col)
            begin
                col_next     = '0;
                pend_ok_next = 1'b0;
                if (last_row)
                begin
                    row_next = '0;
                    rb_next  = '0;
                    tag_next = ~tag_reg;
                end
                else
                begin
                    row_next = RW'(row_p1);
                    rb_next  = IW'(rb_reg + IW'(cfg.eff_w));
                end
            end
            else
            begin
                col_next = CW'(col_p1);
            end
        end

        if (cfg.restart)
        begin
            col_next     = '0;
            row_next     = '0;
            rb_next      = '0;
            pend_ok_next = 1'b0;
            fc_next      = '0;
            tag_next     = ~tag_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_IDLE;
            col_reg      <= '0;
            row_reg      <= '0;
            rb_reg       <= '0;
            pend_ok_reg  <= 1'b0;
            pend_col_reg <= '0;
            tag_reg      <= 1'b0;
            fc_reg       <= '0;
            emit_s_reg   <= 1'b0;
        end
        else
        begin
            phase_reg    <= phase_next;
            col_reg      <= col_next;
            row_reg      <= row_next;
            rb_reg       <= rb_next;
            pend_ok_reg  <= pend_ok_next;
            pend_col_reg <= pend_col_next;
            tag_reg      <= tag_next;
            fc_reg       <= fc_next;
            emit_s_reg   <= emit_s_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            u_s_reg     <= col_reg;
            vb_s_reg    <= rb_reg;
            v0_s_reg    <= (row_reg == '0);
            pv_s_reg    <= in_point;
            pok_s_reg   <= pend_ok_reg;
            pcol_s_reg  <= pend_col_reg;
            tag_s_reg   <= tag_reg;
            lastc_s_reg <= last_col;
            fend_s_reg  <= last_col && last_row;
        end
        if (p1_go)
        begin
            t2_a_reg <= br;
            t2_b_reg <= tr;
            t2_c_reg <= bl;
        end
    end

endmodule
`default_nettype wire

/* rtl/core/ogt_obuf.sv */
// Two-entry output buffer between the sequencer and the result stream.
// Depends on ogt_pkg.
`timescale 1ns / 1ps
`default_nettype none
module ogt_obuf (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           push,
    input  wire ogt_pkg::tri_t                  push_item,
    output logic                                push_ok,
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    output logic      [ogt_pkg::M_TDATA_W-1:0]  m_tdata,
    output logic                                m_tlast
);

    localparam int PAD_W = ogt_pkg::M_TDATA_W - ogt_pkg::FACE_W - 3 * ogt_pkg::IDX_W;

    ogt_pkg::tri_t buf_q [2];
    logic [1:0]    cnt_reg, cnt_next;
    logic          wr_ptr_reg;
    logic          rd_ptr_reg;
    logic          pop;
    ogt_pkg::tri_t head;

    assign push_ok  = (cnt_reg != 2'd2);
    assign m_tvalid = (cnt_reg != 2'd0);
    assign pop      = m_tvalid && m_tready;
    assign head     = buf_q[rd_ptr_reg];
    assign m_tdata  = {PAD_W'(0), head.face_total, head.c, head.b, head.a};
    assign m_tlast  = head.last;

    always_comb
    begin
        cnt_next = cnt_reg;
        case ({push, pop})
            2'b10:   cnt_next = cnt_reg + 2'd1;
            2'b01:   cnt_next = cnt_reg - 2'd1;
            default: cnt_next = cnt_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg    <= '0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (push)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= ~rd_ptr_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            buf_q[wr_ptr_reg] <= push_item;
    end

endmodule
`default_nettype wire

/* rtl/core/ogt_checker.sv */
// Port-level checker for the grid triangulator, bound to the top level.
// Depends on ogt_pkg and organized_grid_triangulator_defines.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "organized_grid_triangulator_defines.svh"
module ogt_checker (
    input wire logic                          clk,
    input wire logic                          rst_n,
    input wire logic                          pready,
    input wire logic                          m_tvalid,
    input wire logic                          m_tready,
    input wire logic [ogt_pkg::M_TDATA_W-1:0] m_tdata,
    input wire logic                          m_tlast
);

    logic                       out_acc;
    logic                       second_due_reg;
    logic [ogt_pkg::FACE_W-1:0] first_ft_reg;
    logic [ogt_pkg::FACE_W-1:0] cur_ft;

    assign out_acc = m_tvalid && m_tready;
    assign cur_ft  = m_tdata[80:60];

    // tracks whether the next triangle must close a pair
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            second_due_reg <= 1'b0;
            first_ft_reg   <= '0;
        end
        else if (out_acc)
        begin
            second_due_reg <= !m_tlast;
            first_ft_reg   <= cur_ft;
        end
    end

    `OGT_ASSERT_NOW(a_pready_high, 1'b1, pready, "pready dropped")
    `OGT_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready,
        m_tvalid && $stable(m_tdata) && $stable(m_tlast), "stalled triangle changed")
    `OGT_ASSERT_NOW(a_pair_order, out_acc, m_tlast == second_due_reg,
        "triangles not in first/second pairs")
    `OGT_ASSERT_NOW(a_face_step,
        out_acc && m_tlast && (first_ft_reg != ogt_pkg::FACE_MAX),
        cur_ft == ogt_pkg::FACE_W'(first_ft_reg + 1'b1), "face count did not step by one")

endmodule

bind organized_grid_triangulator ogt_checker u_ogt_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .pready   (pready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);
`default_nettype wire

/* verif/ogt_face_checker.sv */
// Face checker for the organized grid triangulator: mirrors the column table,
// predicts every triangle of each accepted pixel and compares the face stream.
// Depends on ogt_pkg for field widths, register indexes and the triangle record.
`timescale 1ns / 1ps
module ogt_face_checker (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [ogt_pkg::APB_ADDR_W-1:0]      paddr,
    input  logic [ogt_pkg::APB_DATA_W-1:0]      pwdata,
    input  logic [ogt_pkg::APB_DATA_W-1:0]      prdata,
    input  logic                                pready,
    input  logic                                s_tvalid,
    input  logic                                s_tready,
    input  logic [ogt_pkg::S_TDATA_W-1:0]       s_tdata,   // [0] point_valid
    input  logic                                m_tvalid,
    input  logic                                m_tready,
    input  logic [ogt_pkg::M_TDATA_W-1:0]       m_tdata,   // a, b, c, face_total
    input  logic                                m_tlast,   // last_of_run
    output int                                  fail_count,
    output int                                  faces_pending
);
    import ogt_pkg::*;

    localparam int MAX_W = MAX_WIDTH_DEF;
    localparam int MAX_H = MAX_HEIGHT_DEF;

    // per-column memory: frame parity, row of last valid pixel, its right neighbor
    logic        col_tag         [MAX_W];
    int unsigned col_row         [MAX_W];
    int unsigned col_right       [MAX_W];
    logic        col_right_known [MAX_W];

    logic [CFG_W-1:0]  width_reg;
    logic [CFG_W-1:0]  height_reg;
    int unsigned       col_pos;
    int unsigned       row_pos;
    int unsigned       prev_col;
    logic              prev_known;
    logic              frame_parity;
    logic [FACE_W-1:0] faces_this_frame;

    tri_t face_queue [$];
    int   errors = 0;

    function automatic int unsigned dim_clamp(input int unsigned raw, input int unsigned top);
        if (raw < DIM_MIN)
            return DIM_MIN;
        if (raw > top)
            return top;
        return raw;
    endfunction

    task automatic push_face(input int unsigned a, input int unsigned b, input int unsigned c,
                             input logic last);
        tri_t f;
        if (faces_this_frame < FACE_MAX)
            faces_this_frame++;
        f.a          = a[IDX_W-1:0];
        f.b          = b[IDX_W-1:0];
        f.c          = c[IDX_W-1:0];
        f.face_total = faces_this_frame;
        f.last       = last;
        face_queue.push_back(f);
    endtask

    task automatic flag_field(input string name, input longint unsigned want,
                              input longint unsigned got);
        $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, name, want, got);
        errors++;
    endtask

    always @(posedge clk or negedge rst_n) begin : watch
        tri_t        got;
        tri_t        want;
        int unsigned w;
        int unsigned h;
        int unsigned u;
        int unsigned v;
        int unsigned top_row;
        int unsigned right_col;
        if (!rst_n) begin
            width_reg        = WIDTH_RESET;
            height_reg       = HEIGHT_RESET;
            frame_parity     = 1'b0;
            col_pos          = 0;
            row_pos          = 0;
            prev_col         = 0;
            prev_known       = 1'b0;
            faces_this_frame = '0;
            for (int j = 0; j < MAX_W; j++) begin
                col_tag[j]         = 1'b1;
                col_row[j]         = 0;
                col_right[j]       = 0;
                col_right_known[j] = 1'b0;
            end
            face_queue.delete();
        end
        else begin
            // register traffic; any write restarts the frame
            if (psel && penable && pready) begin
                if (pwrite) begin
                    if (reg_idx_t'(paddr[2]) == REG_FRAME_WIDTH)
                        width_reg = pwdata[CFG_W-1:0];
                    else
                        height_reg = pwdata[CFG_W-1:0];
                    col_pos          = 0;
                    row_pos          = 0;
                    prev_col         = 0;
                    prev_known       = 1'b0;
                    faces_this_frame = '0;
                    frame_parity     = ~frame_parity;
                end
                else if (reg_idx_t'(paddr[2]) == REG_FRAME_WIDTH) begin
                    if (prdata[CFG_W-1:0] !== width_reg)
                        flag_field("frame_width readback", width_reg, prdata[CFG_W-1:0]);
                end
                else if (prdata[CFG_W-1:0] !== height_reg)
                    flag_field("frame_height readback", height_reg, prdata[CFG_W-1:0]);
            end

            // outgoing triangle first: it can't stem from a pixel taken on this edge
            if (m_tvalid && m_tready) begin
                got.a          = m_tdata[IDX_W-1:0];
                got.b          = m_tdata[2*IDX_W-1:IDX_W];
                got.c          = m_tdata[3*IDX_W-1:2*IDX_W];
                got.face_total = m_tdata[3*IDX_W+FACE_W-1:3*IDX_W];
                got.last       = m_tlast;
                if (face_queue.size() == 0) begin
                    $display("%0t ns: unexpected triangle, expected none, got a=%0d b=%0d c=%0d",
                             $time, got.a, got.b, got.c);
                    errors++;
                end
                else begin
                    want = face_queue.pop_front();
                    if (got.a !== want.a)
                        flag_field("corner_a", want.a, got.a);
                    if (got.b !== want.b)
                        flag_field("corner_b", want.b, got.b);
                    if (got.c !== want.c)
                        flag_field("corner_c", want.c, got.c);
                    if (got.face_total !== want.face_total)
                        flag_field("face_total", want.face_total, got.face_total);
                    if (got.last !== want.last)
                        flag_field("last_of_run", want.last, got.last);
                end
            end

            // incoming pixel
            if (s_tvalid && s_tready) begin
                w = dim_clamp(width_reg, MAX_W);
                h = dim_clamp(height_reg, MAX_H);
                u = (col_pos >= w) ? w - 1 : col_pos;
                v = (row_pos >= h) ? h - 1 : row_pos;
                if (s_tdata[0]) begin
                    // this pixel is the right neighbor of the previous valid one
                    if (prev_known && prev_col < MAX_W) begin
                        col_right[prev_col]       = u;
                        col_right_known[prev_col] = 1'b1;
                    end
                    // closes a quad when the pixel above has a known right neighbor
                    if (v > 0 && col_tag[u] == frame_parity && col_right_known[u]) begin
                        top_row   = col_row[u];
                        right_col = col_right[u];
                        push_face(top_row * w + u, top_row * w + right_col, v * w + u, 1'b0);
                        push_face(v * w + right_col, top_row * w + right_col, v * w + u, 1'b1);
                    end
                    col_tag[u]         = frame_parity;
                    col_row[u]         = v;
                    col_right[u]       = 0;
                    col_right_known[u] = 1'b0;
                    prev_col           = u;
                    prev_known         = 1'b1;
                end
                else if (v == 0) begin
                    // top row invalid: entry marked stale for this frame
                    col_tag[u]         = ~frame_parity;
                    col_right_known[u] = 1'b0;
                end
                u++;
                if (u >= w) begin
                    u          = 0;
                    prev_known = 1'b0;
                    v++;
                    if (v >= h) begin
                        v                = 0;
                        frame_parity     = ~frame_parity;
                        faces_this_frame = '0;
                    end
                end
                col_pos = u;
                row_pos = v;
            end
        end
        faces_pending <= face_queue.size();
        fail_count    <= errors;
    end

endmodule

/* verif/testbench.sv */
// Top of the grid triangulator testbench: clock, reset, pixel and register
// stimulus, a stalling face sink, the watchdog and the verdict.
// Depends on ogt_pkg, organized_grid_triangulator and ogt_face_checker.
`timescale 1ns / 1ps
module testbench;
    import ogt_pkg::*;

    localparam int RESET_CYCLES   = 11;
    localparam int SETTLE_CYCLES  = 16;    // lets the pixel pipeline drain
    localparam int HOLD_CYCLES    = 400;   // long sink stall, forces input backpressure
    localparam int WATCHDOG_LIMIT = 5000;  // cycles with no transaction at all
    localparam int RANDOM_ITEMS   = 720;
    localparam int SQUEEZE_PHASE  = 3;     // random phase that runs under the long stall
    localparam int WIDE_PIXELS    = 48;    // start of the top row of a 1024-wide frame

    typedef enum int {
        RX_OPEN,     // always ready
        RX_COIN,     // ready half the time
        RX_SPARSE,   // ready about a quarter of the time
        RX_RHYTHM    // fixed three-on, one-off beat
    } rx_mode_t;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   psel;
    logic                   penable;
    logic                   pwrite;
    logic [APB_ADDR_W-1:0]  paddr;
    logic [APB_DATA_W-1:0]  pwdata;
    logic [APB_DATA_W-1:0]  prdata;
    logic                   pready;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata;   // [0] point_valid, upper bits zero
    logic                   m_tvalid;
    logic                   m_tready;
    logic [M_TDATA_W-1:0]   m_tdata;   // [19:0] a, [39:20] b, [59:40] c, [80:60] face_total
    logic                   m_tlast;   // last_of_run

    int          fail_count;
    int          faces_pending;
    int unsigned burst_left = 0;
    int unsigned quiet_cycles = 0;
    logic        hold_off_req = 1'b0;
    logic        hold_done = 1'b0;

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    organized_grid_triangulator i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    ogt_face_checker i_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tlast       (m_tlast),
        .fail_count    (fail_count),
        .faces_pending (faces_pending)
    );

    // One pixel transaction. The sender runs in bursts; between bursts tvalid
    // drops for a random gap. Within a burst tvalid stays high across items.
    task automatic send_pixel(input logic point_valid);
        int unsigned gap;
        if (burst_left == 0)
        begin
            @(negedge clk);
            s_tvalid <= 1'b0;
            gap = $urandom_range(1, 12);
            repeat (gap - 1) @(negedge clk);
            // now and then a long unbroken burst
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(80, 200)
                                                     : $urandom_range(1, 40);
        end
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tdata  <= {{(S_TDATA_W-1){1'b0}}, point_valid};
        burst_left--;
        do @(posedge clk); while (!s_tready);
    endtask

    // first pixel in bit 0
    task automatic send_pattern(input logic [31:0] bits, input int unsigned count);
        for (int n = 0; n < count; n++)
            send_pixel(bits[n]);
    endtask

    // APB transaction: setup phase, then access phase until pready
    task automatic apb_access(input reg_idx_t idx, input logic wr, input logic [CFG_W-1:0] value);
        logic [APB_DATA_W-1:0] junk;
        junk = $urandom();
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {idx, 2'b00};
        // bits above the register width must be ignored
        pwdata  <= {junk[APB_DATA_W-1:CFG_W], value};
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // New frame size: only once the block has gone quiet. Pixels can finish
    // without a face, so an empty queue alone doesn't mean idle.
    task automatic set_frame(input logic [CFG_W-1:0] w_raw, input logic [CFG_W-1:0] h_raw);
        @(negedge clk);
        s_tvalid <= 1'b0;
        burst_left = 0;
        wait (faces_pending == 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
        apb_access(REG_FRAME_WIDTH, 1'b1, w_raw);
        apb_access(REG_FRAME_WIDTH, 1'b0, '0);
        apb_access(REG_FRAME_HEIGHT, 1'b1, h_raw);
        apb_access(REG_FRAME_HEIGHT, 1'b0, '0);
    endtask

    // Face sink: ready follows a random mode per stretch. Once the squeeze
    // phase is flagged, it shuts for a long count so the block backs up.
    initial
    begin : face_sink
        rx_mode_t    mode;
        int unsigned span;
        m_tready = 1'b0;
        forever
        begin
            if (hold_off_req && !hold_done)
            begin
                @(negedge clk);
                m_tready <= 1'b0;
                for (int n = 0; n < HOLD_CYCLES; n++)
                    @(negedge clk);
                hold_done = 1'b1;
            end
            mode = rx_mode_t'($urandom_range(0, 3));
            span = $urandom_range(4, 60);
            for (int n = 0; n < span; n++)
            begin
                // the long stall starts as soon as it is flagged
                if (hold_off_req && !hold_done)
                    break;
                @(negedge clk);
                case (mode)
                    RX_OPEN:   m_tready <= 1'b1;
                    RX_COIN:   m_tready <= 1'($urandom_range(0, 1));
                    RX_SPARSE: m_tready <= ($urandom_range(0, 3) == 0);
                    default:   m_tready <= (n % 4 != 3);
                endcase
            end
        end
    end

    // Watchdog: any transaction on either stream or the register port resets it.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable && pready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles == WATCHDOG_LIMIT)
            begin
                $display("%0t ns: no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    initial
    begin : stimulus
        int unsigned random_sent;
        int unsigned phase_no;
        int unsigned w_raw;
        int unsigned h_raw;
        int unsigned w_eff;
        int unsigned h_eff;
        int unsigned density;
        int unsigned count;
        rst_n    = 1'b0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;

        // reset size (640x480): part of the top row, then a mid-frame restart
        send_pattern(32'b101101, 6);
        // smallest frame, one quad
        set_frame(2, 2);
        send_pattern(32'b1111, 4);
        // sizes below the minimum act as 2
        set_frame(0, 1);
        send_pattern(32'b1111, 4);
        // 3x3 with a hole in the middle: right neighbor skips, down neighbor skips
        set_frame(3, 3);
        send_pattern(32'b111_101_111, 9);

        // widest and tallest: sizes above the limit clamp to 1024
        set_frame(2047, 2047);
        for (int n = 0; n < WIDE_PIXELS; n++)
            send_pixel($urandom_range(0, 99) < 90);

        // random frames, mostly small so that many rows and frames complete
        random_sent = 0;
        phase_no    = 0;
        while (random_sent < RANDOM_ITEMS)
        begin
            if (phase_no == SQUEEZE_PHASE)
            begin
                w_raw   = 4;
                h_raw   = 4;
                density = 100;
                count   = 64;
            end
            else
            begin
                case ($urandom_range(0, 9))
                    8:       w_raw = $urandom_range(13, 64);
                    9:       w_raw = $urandom_range(0, 2047);
                    default: w_raw = $urandom_range(2, 12);
                endcase
                h_raw = ($urandom_range(0, 9) < 8) ? $urandom_range(2, 8)
                                                   : $urandom_range(0, 2047);
                // mostly dense frames that make faces, some sparse noise
                density = ($urandom_range(0, 9) < 7) ? $urandom_range(70, 100)
                                                     : $urandom_range(0, 50);
                w_eff = (w_raw < DIM_MIN) ? DIM_MIN
                      : (w_raw > MAX_WIDTH_DEF) ? MAX_WIDTH_DEF : w_raw;
                h_eff = (h_raw < DIM_MIN) ? DIM_MIN
                      : (h_raw > MAX_HEIGHT_DEF) ? MAX_HEIGHT_DEF : h_raw;
                // whole frames plus a partial one, cut short for big sizes
                count = $urandom_range(1, 3) * w_eff * h_eff + $urandom_range(0, w_eff);
                if (count > 160)
                    count = $urandom_range(100, 160);
            end
            set_frame(w_raw, h_raw);
            if (phase_no == SQUEEZE_PHASE)
                hold_off_req = 1'b1;
            for (int n = 0; n < count; n++)
                send_pixel($urandom_range(0, 99) < density);
            random_sent += count;
            phase_no++;
        end

        @(negedge clk);
        s_tvalid <= 1'b0;
        wait (faces_pending == 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (fail_count == 0 && faces_pending == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
